@@ hdl/angle_pid_with_wraparound_macros.svh @@
// assertion helpers, sampled on clk and quiet while rst_n is low
`ifndef ANGLE_PID_WITH_WRAPAROUND_MACROS_SVH
`define ANGLE_PID_WITH_WRAPAROUND_MACROS_SVH

// same-cycle implication
`define APW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/apw_pkg.sv @@
`timescale 1ns / 1ps
package apw_pkg;

  localparam int AngleW  = 13;
  localparam int ErrW    = 14;
  localparam int DiffW   = 15;
  localparam int SumW    = 16;
  localparam int GainW   = 16;
  localparam int LimitW  = 15;
  localparam int DriveW  = 16;
  localparam int AccW    = 34;
  localparam int FracW   = 8;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  localparam logic signed [DiffW-1:0] WrapThreshold = 15'sd4000;
  localparam logic signed [DiffW-1:0] WrapSpan      = 15'sd8191;

  localparam logic [GainW-1:0]  KpReset    = 16'd2304;
  localparam logic [GainW-1:0]  KiReset    = 16'd179;
  localparam logic [GainW-1:0]  KdReset    = 16'd2304;
  localparam logic [LimitW-1:0] LimitReset = 15'd1000;

  typedef enum logic [1:0] {
    REG_KP    = 2'd0,
    REG_KI    = 2'd1,
    REG_KD    = 2'd2,
    REG_LIMIT = 2'd3
  } apw_reg_t;

  typedef struct packed {
    logic [AngleW-1:0] target_angle;
    logic [AngleW-1:0] measured_angle;
  } apw_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
  } apw_out_t;

endpackage

@@ hdl/apw_stream_if.sv @@
`timescale 1ns / 1ps
interface apw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/angle_pid_with_wraparound.sv @@
`timescale 1ns / 1ps
// channel   dir  payload                            transfer when
// in_ch     in   target_angle, measured_angle (13u) valid && ready
// out_ch    out  drive (16s)                        valid && ready
// cfg_*     in   apb write, 4 regs at 4*i           psel && penable && pwrite
//
// one item per cycle sustained unless out_ch.ready stalls it; the stages in order:
// product: error wrap, integral update and the three gain multiplies into product regs
// result: sum of products, floor shift by 8, saturate into the result register
// rst_n is synchronous; gains and limit return to defaults, history and sum to zero
// a stalled result holds the product stage, which still takes one more item
module angle_pid_with_wraparound import apw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  apw_stream_if.sink          in_ch,
  apw_stream_if.source        out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  logic [GainW-1:0]  kp_r, ki_r, kd_r;
  logic [LimitW-1:0] limit_r;
  apw_reg_t          cfg_idx;
  logic              cfg_wr;

  logic signed [ErrW-1:0]  prev_err_r, prev_err_nxt;
  logic signed [SumW-1:0]  err_sum_r, err_sum_nxt;

  logic signed [DiffW-1:0]  raw_err, wrap_err;
  logic signed [ErrW-1:0]   err;
  logic signed [DiffW-1:0]  err_diff;
  logic signed [SumW:0]     sum_full, lim_pos, lim_neg;
  logic signed [AccW-1:0]   prop_nxt, der_nxt, int_nxt;
  logic signed [AccW-1:0]   prop_r, der_r, int_r;

  logic signed [AccW-1:0]        acc;
  logic signed [AccW-FracW-1:0]  acc_shr;
  logic signed [DriveW-1:0]      drive_nxt, drive_r;

  logic p_vld_r, p_vld_nxt, out_vld_r, out_vld_nxt;
  logic out_adv, p_adv, in_acc;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = apw_reg_t'(cfg_paddr[CfgAddrW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= KpReset;
      ki_r    <= KiReset;
      kd_r    <= KdReset;
      limit_r <= LimitReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KP:    kp_r    <= cfg_pwdata[GainW-1:0];
        REG_KI:    ki_r    <= cfg_pwdata[GainW-1:0];
        REG_KD:    kd_r    <= cfg_pwdata[GainW-1:0];
        REG_LIMIT: limit_r <= cfg_pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KP:    cfg_prdata = CfgDataW'(kp_r);
      REG_KI:    cfg_prdata = CfgDataW'(ki_r);
      REG_KD:    cfg_prdata = CfgDataW'(kd_r);
      REG_LIMIT: cfg_prdata = CfgDataW'(limit_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // handshake: each stage moves when the one after it is free
  assign out_adv     = !out_vld_r || out_ch.ready;
  assign p_adv       = !p_vld_r || out_adv;
  assign in_ch.ready = rst_n && p_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign p_vld_nxt   = p_adv ? in_acc : p_vld_r;
  assign out_vld_nxt = out_adv ? p_vld_r : out_vld_r;

  // error with short way round the circle
  always_comb begin
    raw_err = $signed({2'b00, in_ch.payload.target_angle})
            - $signed({2'b00, in_ch.payload.measured_angle});
    if (raw_err > WrapThreshold) begin
      wrap_err = raw_err - WrapSpan;
    end else if (raw_err < -WrapThreshold) begin
      wrap_err = raw_err + WrapSpan;
    end else begin
      wrap_err = raw_err;
    end
    err = wrap_err[ErrW-1:0];
  end

  assign err_diff = {err[ErrW-1], err} - {prev_err_r[ErrW-1], prev_err_r};

  // integral update, clamped to the symmetric limit
  always_comb begin
    sum_full = {{(SumW+1-ErrW){err[ErrW-1]}}, err} + {err_sum_r[SumW-1], err_sum_r};
    lim_pos  = $signed({2'b00, limit_r});
    lim_neg  = -lim_pos;
    if (sum_full > lim_pos) begin
      err_sum_nxt = lim_pos[SumW-1:0];
    end else if (sum_full < lim_neg) begin
      err_sum_nxt = lim_neg[SumW-1:0];
    end else begin
      err_sum_nxt = sum_full[SumW-1:0];
    end
  end

  assign prev_err_nxt = err;

  // integral term uses the sum from before this item
  assign prop_nxt = $signed({1'b0, kp_r}) * err;
  assign der_nxt  = $signed({1'b0, kd_r}) * err_diff;
  assign int_nxt  = $signed({1'b0, ki_r}) * err_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      err_sum_r  <= '0;
    end else if (in_acc) begin
      prev_err_r <= prev_err_nxt;
      err_sum_r  <= err_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prop_r <= prop_nxt;
      der_r  <= der_nxt;
      int_r  <= int_nxt;
    end
  end

  // floor shift and saturate
  always_comb begin
    acc     = prop_r + der_r + int_r;
    acc_shr = acc[AccW-1:FracW];
    if (acc_shr > $signed({{(AccW-FracW-DriveW+1){1'b0}}, {(DriveW-1){1'b1}}})) begin
      drive_nxt = {1'b0, {(DriveW-1){1'b1}}};
    end else if (acc_shr < $signed({{(AccW-FracW-DriveW+1){1'b1}}, {(DriveW-1){1'b0}}})) begin
      drive_nxt = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive_nxt = acc_shr[DriveW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && p_vld_r) begin
      drive_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.payload.drive = drive_r;

endmodule

@@ hdl/apw_checker.sv @@
`timescale 1ns / 1ps
`include "angle_pid_with_wraparound_macros.svh"
module apw_checker import apw_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input apw_out_t out_payload
);

  `APW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `APW_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload), "result changed while stalled")
  // with no result waiting the pipeline must be open
  `APW_ASSERT_SAME(a_in_open, !out_valid, in_ready, "input blocked with empty output")
  // a fresh result traces back to an input transfer through the product and result registers
  `APW_ASSERT_SAME(a_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "result without matching input transfer")

endmodule

bind angle_pid_with_wraparound apw_checker u_apw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
